// ----- rtl/pcf_pkg.sv -----
// pcf_pkg: shared types, constants and the CRC-32 byte step for the PNG chunk framer.
// Depends on nothing; every other file imports it.
package pcf_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned LEN_W       = 31;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned STEP_W      = 4;

  localparam logic [WORD_W-1:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [WORD_W-1:0] CRC_INIT = 32'hFFFF_FFFF;

  // serializer step numbers
  localparam logic [STEP_W-1:0] STEP_FIRST      = 4'd0;
  localparam logic [STEP_W-1:0] STEP_TYPE_FIRST = 4'd4;
  localparam logic [STEP_W-1:0] STEP_CRC_FIRST  = 4'd8;
  localparam logic [STEP_W-1:0] STEP_BEGIN_OPEN = 4'd7;
  localparam logic [STEP_W-1:0] STEP_BEGIN_END  = 4'd11;
  localparam logic [STEP_W-1:0] STEP_DATA_END   = 4'd4;

  typedef enum logic {
    OP_BEGIN = 1'b0,
    OP_DATA  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    CMD_BEGIN  = 2'd0,
    CMD_DATA   = 2'd1,
    CMD_MISUSE = 2'd2
  } cmd_kind_e;

  // classified request handed from front to back
  typedef struct packed {
    cmd_kind_e         kind;
    logic [WORD_W-1:0] word;   // chunk type, or data byte in the low bits
    logic [LEN_W-1:0]  len;
    logic              last;   // begin: empty chunk; data: final byte
  } cmd_t;

  // big-endian byte pick, index 0 is the top byte
  function automatic logic [BYTE_W-1:0] word_byte(input logic [WORD_W-1:0] w,
                                                  input logic [1:0] idx);
    logic [BYTE_W-1:0] b;
    case (idx)
      2'd0:    b = w[31:24];
      2'd1:    b = w[23:16];
      2'd2:    b = w[15:8];
      default: b = w[7:0];
    endcase
    return b;
  endfunction

  // reflected CRC-32, one byte folded in
  function automatic logic [WORD_W-1:0] crc_byte(input logic [WORD_W-1:0] crc_in,
                                                 input logic [BYTE_W-1:0] b);
    logic [WORD_W-1:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < BYTE_W; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- rtl/pcf_if.sv -----
// pcf_if: valid/ready channel interfaces for requests in and chunk bytes out.
// Depends on pcf_pkg for field widths.
interface pcf_in_if;
  import pcf_pkg::*;
  logic              valid;
  logic              ready;
  logic              operation;
  logic [WORD_W-1:0] chunk_type;
  logic [LEN_W-1:0]  chunk_length;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, operation, chunk_type, chunk_length, data_byte,
                  input ready);
  modport sink   (input valid, operation, chunk_type, chunk_length, data_byte,
                  output ready);
endinterface

interface pcf_out_if;
  import pcf_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              byte_valid;
  logic              chunk_end;
  logic              misuse;
  logic              last_of_run;

  modport source (output valid, out_byte, byte_valid, chunk_end, misuse, last_of_run,
                  input ready);
  modport sink   (input valid, out_byte, byte_valid, chunk_end, misuse, last_of_run,
                  output ready);
endinterface

// ----- rtl/pcf_front.sv -----
// pcf_front: accepts requests, tracks chunk open / bytes remaining, classifies each request.
// Depends on pcf_pkg and pcf_if.
module pcf_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  pcf_in_if.sink        in_i,
  output logic          push_valid_o,
  input  logic          push_ready_i,
  output pcf_pkg::cmd_t push_cmd_o
);
  import pcf_pkg::*;

  logic             open_q, open_d;
  logic [LEN_W-1:0] rem_q, rem_d;
  logic             accept;
  logic             last_byte;

  assign in_i.ready   = push_ready_i;
  assign push_valid_o = in_i.valid;
  assign accept       = in_i.valid && push_ready_i;
  assign last_byte    = (rem_q == LEN_W'(1));

  always_comb begin
    push_cmd_o.word = in_i.chunk_type;
    push_cmd_o.len  = in_i.chunk_length;
    push_cmd_o.last = (in_i.chunk_length == '0);
    push_cmd_o.kind = CMD_BEGIN;
    open_d          = open_q;
    rem_d           = rem_q;
    if (op_e'(in_i.operation) == OP_BEGIN) begin
      open_d = (in_i.chunk_length != '0);
      rem_d  = in_i.chunk_length;
    end else if (!open_q) begin
      push_cmd_o.kind = CMD_MISUSE;
      push_cmd_o.last = 1'b1;
    end else begin
      push_cmd_o.kind = CMD_DATA;
      push_cmd_o.word = {{(WORD_W-BYTE_W){1'b0}}, in_i.data_byte};
      push_cmd_o.last = last_byte;
      open_d          = !last_byte;
      rem_d           = rem_q - LEN_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      rem_q  <= '0;
    end else if (accept) begin
      open_q <= open_d;
      rem_q  <= rem_d;
    end
  end

endmodule

// ----- rtl/pcf_queue.sv -----
// pcf_queue: small first-in first-out buffer of classified requests between front and back.
// Depends on pcf_pkg.
module pcf_queue #(
  parameter int unsigned Depth = pcf_pkg::QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  pcf_pkg::cmd_t push_cmd_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output pcf_pkg::cmd_t pop_cmd_o
);
  import pcf_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_cmd_o    = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// ----- rtl/pcf_back.sv -----
// pcf_back: steps through each request byte by byte, runs the CRC, drives the output register.
// Depends on pcf_pkg and pcf_if.
module pcf_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          pop_valid_i,
  output logic          pop_ready_o,
  input  pcf_pkg::cmd_t pop_cmd_i,
  pcf_out_if.source     out_o
);
  import pcf_pkg::*;

  logic [STEP_W-1:0] step_q, step_d, step_m1, final_step;
  logic [WORD_W-1:0] crc_q, crc_d;
  logic              produce, is_final;
  logic [BYTE_W-1:0] byte_d;
  logic              bval_d, end_d, misuse_d;
  logic              ovalid_q;
  logic [BYTE_W-1:0] obyte_q;
  logic              obval_q, oend_q, omisuse_q, olast_q;

  assign produce  = pop_valid_i && (!ovalid_q || out_o.ready);
  assign step_m1  = step_q - STEP_W'(1);
  assign is_final = (step_q == final_step);
  assign pop_ready_o = produce && is_final;
  assign step_d   = is_final ? STEP_FIRST : step_q + STEP_W'(1);

  always_comb begin
    final_step = STEP_FIRST;
    byte_d     = '0;
    bval_d     = 1'b1;
    end_d      = 1'b0;
    misuse_d   = 1'b0;
    crc_d      = crc_q;
    case (pop_cmd_i.kind)
      CMD_BEGIN: begin
        final_step = pop_cmd_i.last ? STEP_BEGIN_END : STEP_BEGIN_OPEN;
        if (step_q < STEP_TYPE_FIRST) begin
          byte_d = word_byte({1'b0, pop_cmd_i.len}, step_q[1:0]);
        end else if (step_q < STEP_CRC_FIRST) begin
          byte_d = word_byte(pop_cmd_i.word, step_q[1:0]);
          crc_d  = crc_byte((step_q == STEP_TYPE_FIRST) ? CRC_INIT : crc_q, byte_d);
        end else begin
          byte_d = word_byte(~crc_q, step_q[1:0]);
          end_d  = (step_q == STEP_BEGIN_END);
        end
      end
      CMD_DATA: begin
        final_step = pop_cmd_i.last ? STEP_DATA_END : STEP_FIRST;
        if (step_q == STEP_FIRST) begin
          byte_d = pop_cmd_i.word[BYTE_W-1:0];
          crc_d  = crc_byte(crc_q, byte_d);
        end else begin
          byte_d = word_byte(~crc_q, step_m1[1:0]);
          end_d  = (step_q == STEP_DATA_END);
        end
      end
      default: begin
        bval_d   = 1'b0;
        misuse_d = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= STEP_FIRST;
      crc_q    <= CRC_INIT;
      ovalid_q <= 1'b0;
    end else if (produce) begin
      step_q   <= step_d;
      crc_q    <= crc_d;
      ovalid_q <= 1'b1;
    end else if (out_o.ready) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (produce) begin
      obyte_q   <= byte_d;
      obval_q   <= bval_d;
      oend_q    <= end_d;
      omisuse_q <= misuse_d;
      olast_q   <= is_final;
    end
  end

  assign out_o.valid       = ovalid_q;
  assign out_o.out_byte    = obyte_q;
  assign out_o.byte_valid  = obval_q;
  assign out_o.chunk_end   = oend_q;
  assign out_o.misuse      = omisuse_q;
  assign out_o.last_of_run = olast_q;

endmodule

// ----- rtl/png_chunk_framer_crc32_top.sv -----
// PNG chunk framer with CRC-32. A request passes the queue register, then the output register.
// Throughput: one output byte per cycle while the output is ready; data requests flow at
// one per cycle; a begin yields length and type bytes (plus CRC if empty), a closing data
// byte itself and CRC. Queue of QueueDepth requests decouples input from output stalls.
// Reset (rst_ni, async, active low): no chunk open, CRC all ones, queue and output empty.
module png_chunk_framer_crc32_top #(
  parameter int unsigned QueueDepth = pcf_pkg::QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pcf_in_if.sink     in_i,
  pcf_out_if.source  out_o
);
  import pcf_pkg::*;

  // front -> queue
  logic push_valid, push_ready;
  cmd_t push_cmd;
  // queue -> back
  logic pop_valid, pop_ready;
  cmd_t pop_cmd;

  // Front: takes a request every cycle the queue has room, decides begin / data /
  // misuse against the open-chunk state and the remaining byte count.
  pcf_front u_front (
    .clk_i,
    .rst_ni,
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_cmd_o   (push_cmd)
  );

  // Queue: lets the front keep accepting while the back expands a header or CRC.
  pcf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i,
    .rst_ni,
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  // Back: one byte per cycle into the output register unless the output stalls; owns
  // the CRC register, folding type bytes as they leave and each data byte as it passes.
  pcf_back u_back (
    .clk_i,
    .rst_ni,
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_cmd_i   (pop_cmd),
    .out_o       (out_o)
  );

endmodule
